// ===== rtl/lra_pkg.sv =====
// ============================================================================
// lra_pkg - shared types and constants of the LED ring angle renderer
// Word layouts, map entry type, cell and controller codes, angle helpers.
// ============================================================================
package lra_pkg;

    // One full turn in hundredths of a degree.
    localparam logic [16:0] FULL_TURN = 17'd36000;

    // Action codes of an input word.
    localparam logic [1:0] ACT_SEGMENT = 2'd0;
    localparam logic [1:0] ACT_DOT     = 2'd1;
    localparam logic [1:0] ACT_LINE    = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // Divider step counts for the two kinds of division.
    localparam logic [4:0] DIV_STEPS_SEG   = 5'd16;
    localparam logic [4:0] DIV_STEPS_SHARE = 5'd8;

    typedef logic [15:0] t_angle;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] first_pixel;
        t_angle     first_angle;
        logic [4:0] second_pixel;
        t_angle     second_angle;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       final_segment;
    } t_in_word;

    typedef struct packed {
        logic [4:0] pixel_index;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       last_write;
    } t_out_word;

    typedef struct packed {
        t_angle     angle;
        logic [4:0] pixel;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_SORT_EVEN,
        CELL_SORT_ODD
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SEG_DIV,
        ST_SEG_PRE,
        ST_SEG_WR,
        ST_SEG_POST,
        ST_SORT,
        ST_SCAN,
        ST_GAPS,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_PUSH,
        ST_HITS,
        ST_FLUSH
    } t_state;

    // Forward distance from one angle to another around the ring.
    function automatic t_angle angle_gap(input t_angle from_a, input t_angle to_a);
        logic [16:0] s;
        if (to_a < from_a) begin
            s = {1'b0, to_a} + FULL_TURN - {1'b0, from_a};
        end else begin
            s = {1'b0, to_a} - {1'b0, from_a};
        end
        return s[15:0];
    endfunction

    // Fold a 16-bit angle into one turn.
    function automatic t_angle reduce_angle(input t_angle a);
        logic [16:0] s;
        s = {1'b0, a};
        if (s >= FULL_TURN) begin
            s = s - FULL_TURN;
        end
        return s[15:0];
    endfunction

endpackage

// ===== rtl/lra_cell.sv =====
// ============================================================================
// lra_cell - one map cell of the ring
// Holds one angle/pixel entry; rotates toward the head or does one
// compare-exchange step of the odd-even transposition sort with a neighbor.
// ============================================================================
module lra_cell #(
    parameter int IDX = 0,
    parameter int NUM = 24
) (
    input  logic               i_clk,
    input  lra_pkg::t_cell_ctl i_ctl,
    input  lra_pkg::t_entry    i_left,
    input  lra_pkg::t_entry    i_right,
    output lra_pkg::t_entry    o_entry
);

    localparam bit IS_ODD    = (IDX % 2) == 1;
    localparam bit HAS_LEFT  = IDX > 0;
    localparam bit HAS_RIGHT = IDX < NUM - 1;

    lra_pkg::t_entry r_entry;
    lra_pkg::t_entry n_entry;
    logic            w_right_pair;

    // In an even phase the pairs start at even cells, in an odd phase at odd ones.
    assign w_right_pair = (IS_ODD == (i_ctl.op == lra_pkg::CELL_SORT_ODD));

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            lra_pkg::CELL_HOLD: begin
                n_entry = r_entry;
            end
            lra_pkg::CELL_ROTATE: begin
                n_entry = i_right;
            end
            lra_pkg::CELL_SORT_EVEN, lra_pkg::CELL_SORT_ODD: begin
                // Swap only on a strict inversion so equal angles keep their order.
                if (w_right_pair) begin
                    if (HAS_RIGHT && (r_entry.angle > i_right.angle)) begin
                        n_entry = i_right;
                    end
                end else begin
                    if (HAS_LEFT && (i_left.angle > r_entry.angle)) begin
                        n_entry = i_left;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/lra_div.sv =====
// ============================================================================
// lra_div - iterative restoring divider
// One quotient bit per cycle for a preset number of steps, 16-bit divisor.
// ============================================================================
module lra_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [4:0]  i_steps,
    input  logic [15:0] i_rem_init,
    input  logic [15:0] i_bits,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot,
    output logic [15:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_rq;
    logic [15:0] r_den;
    logic [16:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_rq[15]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem_init;
            r_rq  <= i_bits;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            r_rq  <= {r_rq[14:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_rq;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/led_ring_angle_renderer.sv =====
// ============================================================================
// led_ring_angle_renderer - angle map and dot/line renderer for an LED ring
// Keeps a pixel-to-angle map in a rotating row of cells and turns dot and
// line commands into colored pixel writes.
// ============================================================================
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//  out     | output    | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//
//  One word is handled at a time; o_in_ready is high only while the controller
//  idles. The last result of a word may still wait in the output register.
//  A segment word runs a 16-step divide, then rotations of the cell ring, plus
//  NUM_PIXELS sort phases on a final segment. A dot makes a full scan of the
//  ring, then six 8-step divisions on the shared divider. A line adds a second
//  ring scan, one map entry per cycle unless a stalled result holds the ring.
//  Reset is synchronous and clears only control state; the map is undefined
//  until segment words fill it. A stall on the output freezes the ring.
//
module led_ring_angle_renderer #(
    parameter int NUM_PIXELS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lra_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lra_pkg::t_out_word o_out_word
);

    localparam int SW  = $clog2(NUM_PIXELS);
    localparam int CW  = (SW > 5) ? SW : 5;
    localparam int SPW = $clog2(NUM_PIXELS + 1);
    localparam logic [SW-1:0] POS_LAST = SW'(NUM_PIXELS - 1);
    localparam logic [CW:0]   N_WIDE   = (CW + 1)'(NUM_PIXELS);

    // Controller state.
    lra_pkg::t_state r_state;
    lra_pkg::t_state n_state;

    // Latched word.
    logic [1:0]      r_act;
    logic [4:0]      r_p1;
    logic [4:0]      r_p2;
    lra_pkg::t_angle r_a1;
    lra_pkg::t_angle r_a2;
    logic [7:0]      r_col [0:2];
    logic            r_fin;

    // Ring position: the entry index now sitting in the head cell.
    logic [SW-1:0]   r_pos;
    logic [SW-1:0]   r_k;
    logic [SW-1:0]   r_phase;

    // Segment interpolation: running quotient and remainder of k*delta/span.
    logic [SPW-1:0]  r_span;
    lra_pkg::t_angle r_dq;
    logic [SPW-1:0]  r_dr;
    lra_pkg::t_angle r_q;
    logic [SPW-1:0]  r_rem;

    // Bracket trackers, one for each of the two angles.
    logic            r_found [0:1];
    lra_pkg::t_entry r_lo [0:1];
    lra_pkg::t_entry r_hi [0:1];
    lra_pkg::t_entry r_e0;
    lra_pkg::t_entry r_elast;
    lra_pkg::t_entry r_prev;

    // The two proportional end results.
    lra_pkg::t_angle r_num [0:1];
    lra_pkg::t_angle r_den [0:1];
    logic [4:0]      r_epix [0:1];
    logic            r_e;
    logic [1:0]      r_c;
    logic [23:0]     r_prod;
    logic [7:0]      r_res [0:2];

    // One result is held back so that the last one can be flagged.
    logic               r_pend_v;
    lra_pkg::t_out_word r_pend;
    logic               r_ovalid;
    lra_pkg::t_out_word r_out;

    // Cell ring.
    lra_pkg::t_entry   w_cell [0:NUM_PIXELS-1];
    lra_pkg::t_entry   w_tail_in;
    lra_pkg::t_entry   w_head;
    lra_pkg::t_cell_ctl w_cell_ctl;

    // Divider.
    logic        w_div_start;
    logic [4:0]  w_div_steps;
    logic [15:0] w_div_rem_init;
    logic [15:0] w_div_bits;
    logic [15:0] w_div_den;
    logic        w_div_done;
    logic [15:0] w_div_quot;
    logic [15:0] w_div_rem;

    // Misc combinational values.
    logic               w_slot_free;
    logic               w_push_ok;
    logic               w_pos_last;
    logic               w_at_p1;
    logic               w_reduced;
    logic [CW:0]        w_span_calc;
    logic               w_write_en;
    logic [16:0]        w_wr_sum;
    lra_pkg::t_angle    w_wr_angle;
    logic               w_hit;
    logic               w_rotate;
    logic               w_push;
    logic               w_flush;
    lra_pkg::t_out_word w_new;
    lra_pkg::t_angle    w_num_clamp;
    lra_pkg::t_entry    w_blo [0:1];
    lra_pkg::t_entry    w_bhi [0:1];
    lra_pkg::t_angle    w_gap0;
    lra_pkg::t_angle    w_d_raw;
    lra_pkg::t_angle    w_d_sat;
    logic [SPW:0]       w_rem_sum;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_PIXELS; gi++) begin : g_cell
            lra_pkg::t_entry w_left;
            lra_pkg::t_entry w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_cell[NUM_PIXELS-1];
            end else begin : g_mid_l
                assign w_left = w_cell[gi-1];
            end
            if (gi == NUM_PIXELS - 1) begin : g_last
                assign w_right = w_tail_in;
            end else begin : g_mid_r
                assign w_right = w_cell[gi+1];
            end
            lra_cell #(
                .IDX(gi),
                .NUM(NUM_PIXELS)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_cell_ctl),
                .i_left (w_left),
                .i_right(w_right),
                .o_entry(w_cell[gi])
            );
        end
    endgenerate

    lra_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_steps   (w_div_steps),
        .i_rem_init(w_div_rem_init),
        .i_bits    (w_div_bits),
        .i_den     (w_div_den),
        .o_done    (w_div_done),
        .o_quot    (w_div_quot),
        .o_rem     (w_div_rem)
    );

    assign w_head      = w_cell[0];
    assign w_slot_free = !r_ovalid || i_out_ready;
    assign w_push_ok   = !r_pend_v || w_slot_free;
    assign w_pos_last  = (r_pos == POS_LAST);
    assign w_at_p1     = (CW'(r_pos) == CW'(r_p1));
    assign w_reduced   = ((CW + 1)'(r_p1) < N_WIDE) && ((CW + 1)'(r_p2) < N_WIDE);

    // Number of pixels a segment covers; equal end points mean the whole ring.
    always_comb begin
        if (r_p2 > r_p1) begin
            w_span_calc = (CW + 1)'(r_p2) - (CW + 1)'(r_p1);
        end else begin
            w_span_calc = (CW + 1)'(r_p2) + N_WIDE - (CW + 1)'(r_p1);
        end
    end

    // Interpolated angle for the entry passing the tail during a segment fill.
    assign w_wr_sum   = {1'b0, r_a1} + {1'b0, r_q};
    assign w_wr_angle = (w_wr_sum >= lra_pkg::FULL_TURN) ?
                        16'(w_wr_sum - lra_pkg::FULL_TURN) : w_wr_sum[15:0];
    assign w_write_en = (r_state == lra_pkg::ST_SEG_WR) && (SPW'(r_k) < r_span);

    always_comb begin
        if (w_write_en) begin
            w_tail_in.angle = w_wr_angle;
            w_tail_in.pixel = 5'(r_pos);
        end else begin
            w_tail_in = w_head;
        end
    end

    assign w_rem_sum = (SPW + 1)'(r_rem) + (SPW + 1)'(r_dr);

    // Line range test on the head entry; a range that is not increasing wraps
    // through zero.
    always_comb begin
        if (r_a2 > r_a1) begin
            w_hit = (w_head.angle >= r_a1) && (w_head.angle <= r_a2);
        end else begin
            w_hit = (w_head.angle >= r_a1) || (w_head.angle <= r_a2);
        end
    end

    // Resolve the brackets. An angle below the first entry, at or above the
    // last entry, or with no larger entry found takes the wrap pair.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            lra_pkg::t_angle a;
            logic            wrap;
            a    = (k == 0) ? r_a1 : r_a2;
            wrap = (r_e0.angle > a) || (a >= r_elast.angle) || !r_found[k];
            w_blo[k] = wrap ? r_elast : r_lo[k];
            w_bhi[k] = wrap ? r_e0 : r_hi[k];
        end
    end

    assign w_gap0  = lra_pkg::angle_gap(w_blo[0].angle, w_bhi[0].angle);
    assign w_d_raw = lra_pkg::angle_gap(w_blo[0].angle, r_a1);
    assign w_d_sat = (w_d_raw > w_gap0) ? w_gap0 : w_d_raw;

    assign w_num_clamp = (r_num[r_e] > r_den[r_e]) ? r_den[r_e] : r_num[r_e];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lra_pkg::ST_REDUCE;
                end
            end
            lra_pkg::ST_REDUCE: begin
                if (w_reduced) begin
                    unique case (r_act)
                        lra_pkg::ACT_SEGMENT: n_state = lra_pkg::ST_SEG_DIV;
                        lra_pkg::ACT_DOT:     n_state = lra_pkg::ST_SCAN;
                        lra_pkg::ACT_LINE:    n_state = lra_pkg::ST_SCAN;
                        default:              n_state = lra_pkg::ST_IDLE;
                    endcase
                end
            end
            lra_pkg::ST_SEG_DIV: begin
                if (w_div_done) begin
                    n_state = lra_pkg::ST_SEG_PRE;
                end
            end
            lra_pkg::ST_SEG_PRE: begin
                if (w_at_p1) begin
                    n_state = lra_pkg::ST_SEG_WR;
                end
            end
            lra_pkg::ST_SEG_WR: begin
                if (r_k == POS_LAST) begin
                    n_state = lra_pkg::ST_SEG_POST;
                end
            end
            lra_pkg::ST_SEG_POST: begin
                if (r_pos == '0) begin
                    n_state = r_fin ? lra_pkg::ST_SORT : lra_pkg::ST_IDLE;
                end
            end
            lra_pkg::ST_SORT: begin
                if (r_phase == POS_LAST) begin
                    n_state = lra_pkg::ST_IDLE;
                end
            end
            lra_pkg::ST_SCAN: begin
                if (w_pos_last) begin
                    n_state = lra_pkg::ST_GAPS;
                end
            end
            lra_pkg::ST_GAPS: begin
                n_state = lra_pkg::ST_MUL;
            end
            lra_pkg::ST_MUL: begin
                n_state = lra_pkg::ST_DSTART;
            end
            lra_pkg::ST_DSTART: begin
                n_state = lra_pkg::ST_DIV;
            end
            lra_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = (r_c == 2'd2) ? lra_pkg::ST_PUSH : lra_pkg::ST_MUL;
                end
            end
            lra_pkg::ST_PUSH: begin
                if (w_push_ok) begin
                    if (!r_e) begin
                        n_state = lra_pkg::ST_MUL;
                    end else if (r_act == lra_pkg::ACT_LINE) begin
                        n_state = lra_pkg::ST_HITS;
                    end else begin
                        n_state = lra_pkg::ST_FLUSH;
                    end
                end
            end
            lra_pkg::ST_HITS: begin
                if ((!w_hit || w_push_ok) && w_pos_last) begin
                    n_state = lra_pkg::ST_FLUSH;
                end
            end
            lra_pkg::ST_FLUSH: begin
                if (w_slot_free) begin
                    n_state = lra_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        w_cell_ctl.op  = lra_pkg::CELL_HOLD;
        w_div_start    = 1'b0;
        w_push         = 1'b0;
        w_flush        = 1'b0;
        w_new          = '0;
        w_div_steps    = lra_pkg::DIV_STEPS_SHARE;
        w_div_rem_init = r_prod[23:8];
        w_div_bits     = {r_prod[7:0], 8'h00};
        w_div_den      = r_den[r_e];
        unique case (r_state)
            lra_pkg::ST_REDUCE: begin
                // Segment step size: delta / span, quotient and remainder.
                w_div_start    = w_reduced && (r_act == lra_pkg::ACT_SEGMENT);
                w_div_steps    = lra_pkg::DIV_STEPS_SEG;
                w_div_rem_init = '0;
                w_div_bits     = lra_pkg::angle_gap(r_a1, r_a2);
                w_div_den      = 16'(w_span_calc);
            end
            lra_pkg::ST_SEG_PRE: begin
                if (!w_at_p1) begin
                    w_cell_ctl.op = lra_pkg::CELL_ROTATE;
                end
            end
            lra_pkg::ST_SEG_WR: begin
                w_cell_ctl.op = lra_pkg::CELL_ROTATE;
            end
            lra_pkg::ST_SEG_POST: begin
                if (r_pos != '0) begin
                    w_cell_ctl.op = lra_pkg::CELL_ROTATE;
                end
            end
            lra_pkg::ST_SORT: begin
                w_cell_ctl.op = r_phase[0] ? lra_pkg::CELL_SORT_ODD : lra_pkg::CELL_SORT_EVEN;
            end
            lra_pkg::ST_SCAN: begin
                w_cell_ctl.op = lra_pkg::CELL_ROTATE;
            end
            lra_pkg::ST_DSTART: begin
                w_div_start = 1'b1;
            end
            lra_pkg::ST_PUSH: begin
                w_push            = w_push_ok;
                w_new.pixel_index = r_epix[r_e];
                w_new.out_red     = r_res[0];
                w_new.out_green   = r_res[1];
                w_new.out_blue    = r_res[2];
            end
            lra_pkg::ST_HITS: begin
                if (!w_hit || w_push_ok) begin
                    w_cell_ctl.op = lra_pkg::CELL_ROTATE;
                end
                w_push            = w_hit && w_push_ok;
                w_new.pixel_index = w_head.pixel;
                w_new.out_red     = r_col[0];
                w_new.out_green   = r_col[1];
                w_new.out_blue    = r_col[2];
            end
            lra_pkg::ST_FLUSH: begin
                w_flush = w_slot_free;
            end
            default: begin
                w_cell_ctl.op = lra_pkg::CELL_HOLD;
            end
        endcase
    end

    assign w_rotate = (w_cell_ctl.op == lra_pkg::CELL_ROTATE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lra_pkg::ST_IDLE;
            r_pos    <= '0;
            r_pend_v <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_rotate) begin
                r_pos <= w_pos_last ? '0 : r_pos + 1'b1;
            end
            if (w_flush) begin
                r_ovalid <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (w_push) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_ovalid <= 1'b1;
                end else if (i_out_ready) begin
                    r_ovalid <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_flush) begin
            r_out            <= r_pend;
            r_out.last_write <= 1'b1;
        end else if (w_push) begin
            r_pend <= w_new;
            if (r_pend_v) begin
                r_out <= r_pend;
            end
        end

        unique case (r_state)
            lra_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    r_act      <= i_in_word.action;
                    r_p1       <= i_in_word.first_pixel;
                    r_p2       <= i_in_word.second_pixel;
                    r_a1       <= lra_pkg::reduce_angle(i_in_word.first_angle);
                    r_a2       <= lra_pkg::reduce_angle(i_in_word.second_angle);
                    r_col[0]   <= i_in_word.red;
                    r_col[1]   <= i_in_word.green;
                    r_col[2]   <= i_in_word.blue;
                    r_fin      <= i_in_word.final_segment;
                    r_found[0] <= 1'b0;
                    r_found[1] <= 1'b0;
                end
            end
            lra_pkg::ST_REDUCE: begin
                // Control point pixels fold into the ring one subtraction a cycle.
                if ((CW + 1)'(r_p1) >= N_WIDE) begin
                    r_p1 <= 5'((CW + 1)'(r_p1) - N_WIDE);
                end
                if ((CW + 1)'(r_p2) >= N_WIDE) begin
                    r_p2 <= 5'((CW + 1)'(r_p2) - N_WIDE);
                end
                r_span <= SPW'(w_span_calc);
            end
            lra_pkg::ST_SEG_DIV: begin
                r_dq  <= w_div_quot;
                r_dr  <= SPW'(w_div_rem);
                r_q   <= '0;
                r_rem <= '0;
                r_k   <= '0;
            end
            lra_pkg::ST_SEG_WR: begin
                r_k <= r_k + 1'b1;
                if (w_rem_sum >= (SPW + 1)'(r_span)) begin
                    r_rem <= SPW'(w_rem_sum - (SPW + 1)'(r_span));
                    r_q   <= r_q + r_dq + 16'd1;
                end else begin
                    r_rem <= SPW'(w_rem_sum);
                    r_q   <= r_q + r_dq;
                end
            end
            lra_pkg::ST_SEG_POST: begin
                r_phase <= '0;
            end
            lra_pkg::ST_SORT: begin
                r_phase <= r_phase + 1'b1;
            end
            lra_pkg::ST_SCAN: begin
                r_prev <= w_head;
                if (r_pos == '0) begin
                    r_e0 <= w_head;
                end
                if (w_pos_last) begin
                    r_elast <= w_head;
                end
                for (int k = 0; k < 2; k++) begin
                    if ((r_pos != '0) && !r_found[k] &&
                        (w_head.angle > ((k == 0) ? r_a1 : r_a2))) begin
                        r_found[k] <= 1'b1;
                        r_lo[k]    <= r_prev;
                        r_hi[k]    <= w_head;
                    end
                end
            end
            lra_pkg::ST_GAPS: begin
                r_e <= 1'b0;
                r_c <= 2'd0;
                if (r_act == lra_pkg::ACT_DOT) begin
                    r_num[0]  <= w_gap0 - w_d_sat;
                    r_den[0]  <= w_gap0;
                    r_epix[0] <= w_blo[0].pixel;
                    r_num[1]  <= w_d_sat;
                    r_den[1]  <= w_gap0;
                    r_epix[1] <= w_bhi[0].pixel;
                end else begin
                    r_num[0]  <= lra_pkg::angle_gap(r_a1, w_bhi[0].angle);
                    r_den[0]  <= w_gap0;
                    r_epix[0] <= w_blo[0].pixel;
                    r_num[1]  <= lra_pkg::angle_gap(w_blo[1].angle, r_a2);
                    r_den[1]  <= lra_pkg::angle_gap(w_blo[1].angle, w_bhi[1].angle);
                    r_epix[1] <= w_bhi[1].pixel;
                end
            end
            lra_pkg::ST_MUL: begin
                r_prod <= 24'(r_col[r_c]) * 24'(w_num_clamp);
            end
            lra_pkg::ST_DIV: begin
                if (w_div_done) begin
                    // A zero gap gives a dark share.
                    r_res[r_c] <= (r_den[r_e] == '0) ? 8'd0 : w_div_quot[7:0];
                    if (r_c != 2'd2) begin
                        r_c <= r_c + 2'd1;
                    end
                end
            end
            lra_pkg::ST_PUSH: begin
                if (w_push_ok) begin
                    r_e <= 1'b1;
                    r_c <= 2'd0;
                end
            end
            default: begin
                r_prev <= r_prev;
            end
        endcase
    end

    assign o_in_ready  = (r_state == lra_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

endmodule

// ===== rtl/lra_checker.sv =====
// ============================================================================
// lra_checker - port-level checks for the LED ring angle renderer
// Watches the handshakes and the result stream on the top-level ports.
// ============================================================================
module lra_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input lra_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lra_pkg::t_out_word o_out_word
);

    // A waiting input word stays offered and unchanged until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_word)))
        else $error("input word changed or withdrawn while waiting");

    // A waiting result word stays valid and unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed or dropped while stalled");

    // Words are handled one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after an accept");

    // While a result that is not the last is shown, its word is still in work.
    a_busy_mid_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last_write) |-> !o_in_ready)
        else $error("ready for a new word before the last result was issued");

    // Reset leaves no result pending.
    a_reset_clean: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind led_ring_angle_renderer lra_checker u_lra_checker (.*);
